// File: rtl/lfb_pkg.sv
// shared types and constants of the link frame builder
package lfb_pkg;

	// command codes carried in s_axis_tuser
	localparam logic [1:0] CMD_DATA   = 2'd0;
	localparam logic [1:0] CMD_SUPV   = 2'd1;
	localparam logic [1:0] CMD_EMPTY  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FLAG   = 2'd0;
	localparam logic [1:0] CFG_ESCAPE = 2'd1;
	localparam logic [1:0] CFG_MASK   = 2'd2;

	localparam logic [7:0] FLAG_RESET   = 8'd126;
	localparam logic [7:0] ESCAPE_RESET = 8'd125;
	localparam logic [7:0] MASK_RESET   = 8'd32;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] stuff_mask;
	} cfg_t;

	// one classified request, as the back end plays it out
	typedef struct packed {
		logic       hdr;
		logic [7:0] frame_address;
		logic [7:0] frame_control;
		logic       has_data;
		logic [7:0] data_byte;
		logic       has_bcc;
		logic [7:0] bcc;
		logic       close;
	} job_t;

	typedef enum logic [3:0] {
		BK_START,
		BK_FLAG,
		BK_ADDR,
		BK_CTRL,
		BK_HCHK,
		BK_DATA,
		BK_DATA_ESC,
		BK_BCC,
		BK_BCC_ESC,
		BK_CLOSE
	} step_t;

endpackage

// File: rtl/lfb_front.sv
// front end: accepts requests, tracks the open frame and running check, builds jobs
module lfb_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [1:0]  cmd,
	input  logic [7:0]  frame_address,
	input  logic [7:0]  frame_control,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        push,
	output lfb_pkg::job_t job
);
	import lfb_pkg::*;

	logic [7:0] running_check_q;
	logic       frame_open_q;
	logic [7:0] run_nxt;
	logic       open_nxt;
	logic       opening;
	logic [7:0] sum;

	always_comb begin
		opening  = first_byte | ~frame_open_q;
		sum      = (opening ? 8'd0 : running_check_q) ^ data_byte;
		push     = 1'b0;
		run_nxt  = running_check_q;
		open_nxt = frame_open_q;
		job.hdr           = 1'b1;
		job.frame_address = frame_address;
		job.frame_control = frame_control;
		job.has_data      = 1'b0;
		job.data_byte     = data_byte;
		job.has_bcc       = 1'b0;
		job.bcc           = 8'd0;
		job.close         = 1'b1;
		unique case (cmd)
			CMD_DATA: begin
				push         = accept;
				job.hdr      = opening;
				job.has_data = 1'b1;
				job.has_bcc  = last_byte;
				job.bcc      = sum;
				job.close    = last_byte;
				run_nxt      = last_byte ? 8'd0 : sum;
				open_nxt     = ~last_byte;
			end
			CMD_SUPV: begin
				push     = accept;
				run_nxt  = 8'd0;
				open_nxt = 1'b0;
			end
			CMD_EMPTY: begin
				push        = accept;
				job.has_bcc = 1'b1;
				run_nxt     = 8'd0;
				open_nxt    = 1'b0;
			end
			default: begin
				// unused command is dropped without effect
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_check_q <= 8'd0;
			frame_open_q    <= 1'b0;
		end else if (push) begin
			running_check_q <= run_nxt;
			frame_open_q    <= open_nxt;
		end
	end

endmodule

// File: rtl/lfb_queue.sv
// small job queue between front and back end
module lfb_queue #(
	parameter int DEPTH = lfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lfb_pkg::job_t wr_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output lfb_pkg::job_t head_job
);
	import lfb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/lfb_back.sv
// back end: plays a job out byte by byte with stuffing into the output register
module lfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  lfb_pkg::cfg_t cfg,
	input  logic          head_valid,
	input  lfb_pkg::job_t head_job,
	output logic          pop,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [7:0]    m_axis_tdata,   // out_byte
	output logic          m_axis_tuser,   // end_of_frame
	output logic          m_axis_tlast    // end_of_run
);
	import lfb_pkg::*;

	step_t      step_q;
	step_t      cur_step;
	step_t      nxt_step;
	logic       advance;
	logic       data_special;
	logic       bcc_special;
	logic [7:0] byte_d;
	logic       eof_d;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_eof_q;
	logic       out_eor_q;

	assign data_special = (head_job.data_byte == cfg.flag_byte) ||
	                      (head_job.data_byte == cfg.escape_byte);
	assign bcc_special  = (head_job.bcc == cfg.flag_byte) ||
	                      (head_job.bcc == cfg.escape_byte);
	assign advance      = head_valid & (~out_valid_q | m_axis_tready);

	// current and next step of the job at the queue head
	always_comb begin
		if (step_q != BK_START) begin
			cur_step = step_q;
		end else if (head_job.hdr) begin
			cur_step = BK_FLAG;
		end else if (head_job.has_data) begin
			cur_step = BK_DATA;
		end else if (head_job.has_bcc) begin
			cur_step = BK_BCC;
		end else begin
			cur_step = BK_CLOSE;
		end
		nxt_step = BK_START;
		unique case (cur_step)
			BK_FLAG: nxt_step = BK_ADDR;
			BK_ADDR: nxt_step = BK_CTRL;
			BK_CTRL: nxt_step = BK_HCHK;
			BK_HCHK, BK_DATA, BK_DATA_ESC: begin
				if (cur_step == BK_HCHK && head_job.has_data) begin
					nxt_step = BK_DATA;
				end else if (cur_step == BK_DATA && data_special) begin
					nxt_step = BK_DATA_ESC;
				end else if (head_job.has_bcc) begin
					nxt_step = BK_BCC;
				end else if (head_job.close) begin
					nxt_step = BK_CLOSE;
				end else begin
					nxt_step = BK_START;
				end
			end
			BK_BCC, BK_BCC_ESC: begin
				if (cur_step == BK_BCC && bcc_special) begin
					nxt_step = BK_BCC_ESC;
				end else if (head_job.close) begin
					nxt_step = BK_CLOSE;
				end else begin
					nxt_step = BK_START;
				end
			end
			BK_CLOSE: nxt_step = BK_START;
			default:  nxt_step = BK_START;
		endcase
	end

	// byte for the current step
	always_comb begin
		byte_d = cfg.flag_byte;
		eof_d  = 1'b0;
		unique case (cur_step)
			BK_FLAG:     byte_d = cfg.flag_byte;
			BK_ADDR:     byte_d = head_job.frame_address;
			BK_CTRL:     byte_d = head_job.frame_control;
			BK_HCHK:     byte_d = head_job.frame_address ^ head_job.frame_control;
			BK_DATA:     byte_d = data_special ? cfg.escape_byte : head_job.data_byte;
			BK_DATA_ESC: byte_d = head_job.data_byte ^ cfg.stuff_mask;
			BK_BCC:      byte_d = bcc_special ? cfg.escape_byte : head_job.bcc;
			BK_BCC_ESC:  byte_d = head_job.bcc ^ cfg.stuff_mask;
			BK_CLOSE: begin
				byte_d = cfg.flag_byte;
				eof_d  = 1'b1;
			end
			default:     byte_d = cfg.flag_byte;
		endcase
	end

	assign pop = advance & (nxt_step == BK_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= BK_START;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= nxt_step;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			out_eof_q  <= eof_d;
			out_eor_q  <= (nxt_step == BK_START);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_eof_q;
	assign m_axis_tlast  = out_eor_q;

endmodule

// File: rtl/link_frame_builder.sv
// top level of the link frame builder: config registers, front, queue, back
//
// Requests enter on the s_axis stream: cmd selects a payload byte, a
// supervision frame or an empty information frame; address and control form
// the header when a frame opens. Bytes of the frame leave one per cycle on the
// m_axis stream while a job waits and the receiver is ready; tlast marks the
// last byte caused by one request and tuser marks the closing flag.
// A request is classified at once into a job for a small queue (QUEUE_DEPTH
// entries). The back end sends one byte per cycle while the receiver is
// ready: a stuffed byte as escape and masked byte, a header as flag, address,
// control and header check, a close as check (stuffed if needed) and flag.
// The first byte of a request passes through the queue and the output
// register before it is valid on m_axis. s_axis_tready drops only while the
// queue is full, so a stalled receiver backs up into the queue before it
// holds off the sender. Reset clears the queue, the output valid flag, the
// running check and the open-frame state, and loads the delimiter, escape
// and mask defaults. Configuration writes are taken whenever cfg_we is high
// and apply to bytes sent afterwards.
module link_frame_builder #(
	parameter int QUEUE_DEPTH = lfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // frame_address, frame_control, data_byte
	input  logic [2:0]  s_axis_tuser,   // cmd, first_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic        m_axis_tuser,   // end_of_frame
	output logic        m_axis_tlast    // end_of_run
);
	import lfb_pkg::*;

	cfg_t cfg_q;
	job_t push_job;
	job_t head_job;
	logic push;
	logic q_full;
	logic head_valid;
	logic pop;
	logic in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte   <= FLAG_RESET;
			cfg_q.escape_byte <= ESCAPE_RESET;
			cfg_q.stuff_mask  <= MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLAG:   cfg_q.flag_byte   <= cfg_data;
				CFG_ESCAPE: cfg_q.escape_byte <= cfg_data;
				CFG_MASK:   cfg_q.stuff_mask  <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	assign s_axis_tready = ~q_full;
	assign in_accept     = s_axis_tvalid & s_axis_tready;

	lfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.cmd           (s_axis_tuser[1:0]),
		.frame_address (s_axis_tdata[7:0]),
		.frame_control (s_axis_tdata[15:8]),
		.data_byte     (s_axis_tdata[23:16]),
		.first_byte    (s_axis_tuser[2]),
		.last_byte     (s_axis_tlast),
		.push          (push),
		.job           (push_job)
	);

	lfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head_valid    (head_valid),
		.head_job      (head_job),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// the closing flag always ends its run
	a_close_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("closing flag not marked as end of run");

	// retiring a job leaves its final byte in the output register
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid && m_axis_tlast)
		else $error("job retired without end-of-run byte");

	// no job is pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

// File: dv/tb_link_frame_builder.sv
// testbench of link_frame_builder: directed table and random frames checked by a predictor
module tb_link_frame_builder;
	import lfb_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam logic [3:0] NOT_TYPED    = 4'hF;
	localparam int         NUM_DIR      = 18;
	localparam int         RANDOM_ITEMS = 96;
	localparam int         SETTLE       = 16;
	localparam int         STALL_LIMIT  = 2000;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] addr;
		logic [7:0] ctrl;
		logic [7:0] data;
		logic       first;
		logic       last;
	} frame_req_t;

	typedef struct {
		logic [7:0] octet;
		logic       run_end;
		logic       frame_end;
	} line_byte_t;

	// typed rows list their bytes in line order, first byte in the highest used bits
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  addr;
		logic [7:0]  ctrl;
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [3:0]  n_typed;
		logic [71:0] typed;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_FLAG;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = 24'h0;
	logic [2:0]  s_axis_tuser = 3'h0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	// predictor state
	cfg_t       line_cfg;
	logic [7:0] bcc_acc;
	logic       frame_is_open;
	line_byte_t next_run[$];
	line_byte_t line_q[$];

	int send_gap_pct;
	int rcv_gap_pct;
	int errors = 0;
	int n_items = 0;
	int n_unused = 0;
	int n_counted = 0;
	int n_checked = 0;
	int n_closes = 0;
	int stall_cycles = 0;

	table_row_t directed_rows [NUM_DIR];

	link_frame_builder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void emit(input logic [7:0] b, input logic eof);
		line_byte_t e;
		e.octet = b;
		e.run_end = 1'b0;
		e.frame_end = eof;
		next_run.push_back(e);
	endfunction

	function automatic void emit_stuffed(input logic [7:0] b);
		if (b == line_cfg.flag_byte || b == line_cfg.escape_byte) begin
			emit(line_cfg.escape_byte, 1'b0);
			emit(b ^ line_cfg.stuff_mask, 1'b0);
		end else begin
			emit(b, 1'b0);
		end
	endfunction

	function automatic void emit_header(input logic [7:0] a, input logic [7:0] c);
		emit(line_cfg.flag_byte, 1'b0);
		emit(a, 1'b0);
		emit(c, 1'b0);
		emit(a ^ c, 1'b0);
	endfunction

	// line bytes that one request produces, left in next_run
	function automatic void predict_run(input frame_req_t r);
		line_byte_t tail;
		next_run.delete();
		case (r.cmd)
			CMD_DATA: begin
				if (r.first || !frame_is_open) begin
					emit_header(r.addr, r.ctrl);
					bcc_acc = 8'h00;
					frame_is_open = 1'b1;
				end
				emit_stuffed(r.data);
				bcc_acc = bcc_acc ^ r.data;
				if (r.last) begin
					emit_stuffed(bcc_acc);
					emit(line_cfg.flag_byte, 1'b1);
					bcc_acc = 8'h00;
					frame_is_open = 1'b0;
				end
			end
			CMD_SUPV: begin
				emit_header(r.addr, r.ctrl);
				emit(line_cfg.flag_byte, 1'b1);
				bcc_acc = 8'h00;
				frame_is_open = 1'b0;
			end
			CMD_EMPTY: begin
				emit_header(r.addr, r.ctrl);
				emit_stuffed(8'h00);
				emit(line_cfg.flag_byte, 1'b1);
				bcc_acc = 8'h00;
				frame_is_open = 1'b0;
			end
			default: begin
				// unused command: nothing sent, state kept
			end
		endcase
		if (next_run.size() > 0) begin
			tail = next_run.pop_back();
			tail.run_end = 1'b1;
			next_run.push_back(tail);
		end
	endfunction

	// payload biased toward the bytes that need stuffing
	function automatic logic [7:0] pick_payload();
		int p;
		p = $urandom_range(99);
		if (p < 20)
			return line_cfg.flag_byte;
		if (p < 35)
			return line_cfg.escape_byte;
		if (p < 40)
			return line_cfg.flag_byte ^ line_cfg.stuff_mask;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_item(input frame_req_t r, input logic [3:0] n_typed,
			input logic [71:0] typed);
		int gap;
		int n;
		line_byte_t e;
		gap = 0;
		while ($urandom_range(99) < send_gap_pct && gap < 60)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {r.data, r.ctrl, r.addr};
		s_axis_tuser  <= {r.first, r.cmd};
		s_axis_tlast  <= r.last;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_run(r);
		if (n_typed == NOT_TYPED) begin
			foreach (next_run[k])
				line_q.push_back(next_run[k]);
		end else begin
			n = n_typed;
			for (int k = 0; k < n; k++) begin
				e.octet = typed[8*(n-1-k) +: 8];
				e.run_end = (k == n - 1);
				e.frame_end = (k == n - 1);
				line_q.push_back(e);
			end
		end
		n_items++;
		if (r.cmd == CMD_UNUSED)
			n_unused++;
		else
			n_counted++;
	endtask

	// sender holds off until every expected byte is out, then the back end settles
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (line_q.size() > 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	task automatic configure(input cfg_t c);
		hold_until_drained();
		write_reg(CFG_FLAG, c.flag_byte);
		write_reg(CFG_ESCAPE, c.escape_byte);
		write_reg(CFG_MASK, c.stuff_mask);
		cfg_we <= 1'b0;
		line_cfg = c;
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= rcv_gap_pct);
	end

	// output transaction checker
	always @(posedge clk) begin
		line_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_checked++;
			if (line_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected byte: expected none, actual %h tlast %b tuser %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = line_q.pop_front();
				if (want.frame_end)
					n_closes++;
				if (m_axis_tdata !== want.octet) begin
					errors++;
					$display("%0t: out_byte mismatch: expected %h, actual %h",
						$time, want.octet, m_axis_tdata);
				end
				if (m_axis_tlast !== want.run_end) begin
					errors++;
					$display("%0t: end_of_run mismatch: expected %b, actual %b",
						$time, want.run_end, m_axis_tlast);
				end
				if (m_axis_tuser !== want.frame_end) begin
					errors++;
					$display("%0t: end_of_frame mismatch: expected %b, actual %b",
						$time, want.frame_end, m_axis_tuser);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any port
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d bytes still expected",
					$time, stall_cycles, line_q.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		frame_req_t r;
		table_row_t row;
		cfg_t       phase_cfg [4];
		int         phase_items;
		int         pick;
		int         len;

		directed_rows = '{
			{CMD_SUPV,   8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 4'd5, 72'h7E_00_FF_FF_7E},
			{CMD_EMPTY,  8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 4'd6, 72'h7E_FF_FF_00_00_7E},
			{CMD_DATA,   8'h01, 8'h02, 8'h7E, 1'b1, 1'b1, 4'd9, 72'h7E_01_02_03_7D_5E_7D_5E_7E},
			{CMD_DATA,   8'hFF, 8'h00, 8'h7D, 1'b1, 1'b1, 4'd9, 72'h7E_FF_00_FF_7D_5D_7D_5D_7E},
			{CMD_DATA,   8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 4'd7, 72'h7E_00_00_00_00_00_7E},
			{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 4'd0, 72'h0},
			// frame opened without first, unused command in the middle
			{CMD_DATA,   8'h12, 8'h34, 8'hFF, 1'b0, 1'b0, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'h00, 8'h00, 8'h7E, 1'b0, 1'b0, NOT_TYPED, 72'h0},
			{CMD_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'h00, 8'h00, 8'h7D, 1'b0, 1'b1, NOT_TYPED, 72'h0},
			// abandoned frames
			{CMD_DATA,   8'hAA, 8'h55, 8'h01, 1'b1, 1'b0, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'h55, 8'hAA, 8'h80, 1'b1, 1'b0, NOT_TYPED, 72'h0},
			{CMD_SUPV,   8'h7E, 8'h7D, 8'h00, 1'b0, 1'b0, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'h0F, 8'hF0, 8'h7E, 1'b1, 1'b0, NOT_TYPED, 72'h0},
			{CMD_EMPTY,  8'h00, 8'h00, 8'h00, 1'b0, 1'b1, NOT_TYPED, 72'h0},
			// check byte that needs stuffing
			{CMD_DATA,   8'h33, 8'hCC, 8'h03, 1'b1, 1'b0, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'h33, 8'hCC, 8'h7D, 1'b0, 1'b1, NOT_TYPED, 72'h0},
			{CMD_DATA,   8'hC3, 8'h3C, 8'h5E, 1'b1, 1'b1, NOT_TYPED, 72'h0}
		};
		phase_cfg[0] = '{8'h00, 8'hFF, 8'hFF};
		phase_cfg[1] = '{8'hFF, 8'h00, 8'h00};
		phase_cfg[2] = '{8'h55, 8'h55, 8'hAA};
		phase_cfg[3] = '{8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255))};

		line_cfg = '{FLAG_RESET, ESCAPE_RESET, MASK_RESET};
		bcc_acc = 8'h00;
		frame_is_open = 1'b0;
		send_gap_pct = 19;
		rcv_gap_pct = 53;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			row = directed_rows[i];
			r.cmd = row.cmd;
			r.addr = row.addr;
			r.ctrl = row.ctrl;
			r.data = row.data;
			r.first = row.first;
			r.last = row.last;
			send_item(r, row.n_typed, row.typed);
		end

		for (int ph = 0; ph < 4; ph++) begin
			configure(phase_cfg[ph]);
			if (ph == 1) begin
				send_gap_pct = 53;
				rcv_gap_pct = 19;
			end else if (ph == 3) begin
				send_gap_pct = 0;
				rcv_gap_pct = 0;
			end

			// empty frame and a stuffed pair under the new setting
			r.cmd = CMD_EMPTY;
			r.addr = 8'($urandom_range(255));
			r.ctrl = 8'($urandom_range(255));
			r.data = 8'h00;
			r.first = 1'b0;
			r.last = 1'b0;
			send_item(r, NOT_TYPED, 72'h0);
			r.cmd = CMD_DATA;
			r.data = line_cfg.flag_byte;
			r.first = 1'b1;
			send_item(r, NOT_TYPED, 72'h0);
			r.data = line_cfg.escape_byte;
			r.first = 1'b0;
			r.last = 1'b1;
			send_item(r, NOT_TYPED, 72'h0);

			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 4) begin
				r.addr = 8'($urandom_range(255));
				r.ctrl = 8'($urandom_range(255));
				r.data = 8'($urandom_range(255));
				r.first = 1'($urandom_range(1));
				r.last = 1'($urandom_range(1));
				pick = $urandom_range(99);
				if (pick < 60) begin
					len = $urandom_range(1, 6);
					for (int k = 0; k < len; k++) begin
						r.cmd = CMD_DATA;
						r.data = pick_payload();
						r.first = (k == 0);
						r.last = (k == len - 1);
						send_item(r, NOT_TYPED, 72'h0);
						r.addr = 8'($urandom_range(255));
						r.ctrl = 8'($urandom_range(255));
					end
					phase_items += len;
				end else begin
					if (pick < 72)
						r.cmd = CMD_SUPV;
					else if (pick < 82)
						r.cmd = CMD_EMPTY;
					else if (pick < 94)
						r.cmd = CMD_DATA;
					else
						r.cmd = CMD_UNUSED;
					send_item(r, NOT_TYPED, 72'h0);
					if (r.cmd != CMD_UNUSED)
						phase_items++;
				end
			end
		end

		hold_until_drained();
		$display("sent %0d requests that build frames and %0d with the unused command, %0d in all",
			n_counted, n_unused, n_items);
		$display("checked %0d line bytes, %0d of them closing flags, under 5 register settings",
			n_checked, n_closes);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
